/* src/ptq_pkg.sv */
`timescale 1ns / 1ps

package ptq_pkg;

    localparam int DATA_W              = 32;
    localparam int PRIO_REQ_W          = 8;
    localparam int DEF_QUEUE_DEPTH     = 16;
    localparam int DEF_PRIORITY_LEVELS = 16;
    localparam int DEF_COUNT_W         = 5;

    typedef enum logic [1:0] {
        CMD_ADD           = 2'd0,
        CMD_TAKE_OLDEST   = 2'd1,
        CMD_TAKE_EQUAL    = 2'd2,
        CMD_TAKE_AT_LEAST = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_FULL         = 3'd1,
        ST_BAD_PRIORITY = 3'd2,
        ST_EMPTY        = 3'd3,
        ST_NO_MATCH     = 3'd4
    } t_status;

endpackage

/* src/ptq_if.sv */
`timescale 1ns / 1ps

interface ptq_cmd_if;
    import ptq_pkg::*;

    logic                             valid;
    logic                             ready;
    t_cmd                             command;
    logic signed [DATA_W-1:0]         entry_data;
    logic        [PRIO_REQ_W-1:0]     priority_req;

    modport source (output valid, output command, output entry_data, output priority_req,
                    input ready);
    modport sink   (input valid, input command, input entry_data, input priority_req,
                    output ready);
endinterface

interface ptq_res_if #(
    parameter int COUNT_W = ptq_pkg::DEF_COUNT_W
);
    import ptq_pkg::*;

    logic                             valid;
    logic                             ready;
    t_status                          status;
    logic signed [DATA_W-1:0]         taken_data;
    logic        [COUNT_W-1:0]        entry_count;

    modport source (output valid, output status, output taken_data, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input taken_data, input entry_count,
                    output ready);
endinterface

/* src/ptq_ram.sv */
`timescale 1ns / 1ps

module ptq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/priority_tagged_queue.sv */
`timescale 1ns / 1ps
// Channel   Direction  Fields
// i_cmd     in         command, entry_data, priority_req
// o_res     out        status, taken_data, entry_count
//
// An add, or a take on an empty queue, passes from acceptance straight to S_DONE, which loads
// the output register. A take on a non-empty queue searches and then closes the gap, wherever
// the match lies: the search reads one slot per cycle and the gap is closed one slot per cycle
// through the single read port of the slot RAM. The input is ready only in S_IDLE, so no item is
// accepted until the last one has left S_DONE. Reset empties the queue at once; slots are not cleared.
// A pending result waits in the output register while the next item is accepted; that item
// then holds the input off until the output register frees.

module priority_tagged_queue
    import ptq_pkg::*;
#(
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ptq_cmd_if.sink   i_cmd,
    ptq_res_if.source o_res
);

    localparam int AddrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CountW = $clog2(QUEUE_DEPTH + 1);
    localparam int TagW   = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int SlotW  = DATA_W + TagW;
    localparam logic [CountW-1:0]   FullCount = CountW'(QUEUE_DEPTH);
    localparam logic [CountW-1:0]   OneCount  = CountW'(1);
    localparam logic [PRIO_REQ_W:0] PrioLimit = (PRIO_REQ_W + 1)'(PRIORITY_LEVELS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state                   r_state,      n_state;
    t_cmd                     r_cmd,        n_cmd;
    logic [PRIO_REQ_W-1:0]    r_prio,       n_prio;
    logic [CountW-1:0]        r_count,      n_count;
    logic [CountW-1:0]        r_idx,        n_idx;
    logic                     r_pend,       n_pend;
    logic [AddrW-1:0]         r_wp,         n_wp;
    t_status                  r_status,     n_status;
    logic signed [DATA_W-1:0] r_taken,      n_taken;
    logic                     r_out_valid,  n_out_valid;
    t_status                  r_out_status, n_out_status;
    logic signed [DATA_W-1:0] r_out_data,   n_out_data;
    logic [CountW-1:0]        r_out_count,  n_out_count;

    logic                  ram_we;
    logic [AddrW-1:0]      ram_waddr;
    logic [SlotW-1:0]      ram_wdata;
    logic [AddrW-1:0]      ram_raddr;
    logic [SlotW-1:0]      ram_rdata;
    logic [PRIO_REQ_W-1:0] slot_tag;
    logic                  hit;

    ptq_ram #(
        .WIDTH  (SlotW),
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (AddrW)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_tag = PRIO_REQ_W'(ram_rdata[SlotW-1:DATA_W]);

    always_comb begin
        case (r_cmd)
            CMD_TAKE_OLDEST:   hit = 1'b1;
            CMD_TAKE_EQUAL:    hit = (slot_tag == r_prio);
            CMD_TAKE_AT_LEAST: hit = (slot_tag >= r_prio);
            default:           hit = 1'b0;
        endcase
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.taken_data  = r_out_data;
    assign o_res.entry_count = r_out_count;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_prio       = r_prio;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_wp         = r_wp;
        n_status     = r_status;
        n_taken      = r_taken;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_wp;
        ram_wdata    = ram_rdata;
        ram_raddr    = r_idx[AddrW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd    = i_cmd.command;
                    n_prio   = i_cmd.priority_req;
                    n_taken  = '0;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    if (i_cmd.command == CMD_ADD) begin
                        if (r_count == FullCount) begin
                            n_status = ST_FULL;
                        end else if ({1'b0, i_cmd.priority_req} >= PrioLimit) begin
                            n_status = ST_BAD_PRIORITY;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[AddrW-1:0];
                            ram_wdata = {i_cmd.priority_req[TagW-1:0], i_cmd.entry_data};
                            n_count   = r_count + OneCount;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!r_pend) begin
                    n_idx  = r_idx + OneCount;
                    n_pend = 1'b1;
                end else if (hit) begin
                    n_taken = ram_rdata[DATA_W-1:0];
                    n_wp    = AddrW'(r_idx - OneCount);
                    if (r_idx < r_count) begin
                        n_idx   = r_idx + OneCount;
                        n_state = S_SHIFT;
                    end else begin
                        n_count = r_count - OneCount;
                        n_state = S_DONE;
                    end
                end else if (r_idx == r_count) begin
                    n_status = ST_NO_MATCH;
                    n_state  = S_DONE;
                end else begin
                    n_idx = r_idx + OneCount;
                end
            end
            S_SHIFT: begin
                ram_we = 1'b1;
                if (r_idx == r_count) begin
                    n_count = r_count - OneCount;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + OneCount;
                    n_wp  = r_wp + AddrW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_data   = r_taken;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_cmd        <= n_cmd;
            r_prio       <= n_prio;
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            r_wp         <= n_wp;
            r_status     <= n_status;
            r_taken      <= n_taken;
            r_out_status <= n_out_status;
            r_out_data   <= n_out_data;
            r_out_count  <= n_out_count;
        end
    end

endmodule
